FILE: src/dvfc_pkg.sv
`timescale 1ns / 1ps

package dvfc_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int COUNT_WIDTH = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int OCC_WIDTH   = 16;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Depth of the item queue in front and of the result queue at the back.
    localparam int IQ_DEPTH = 4;
    localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
    localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [OCC_WIDTH-1:0]   t_occ;
    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [CNT_W-1:0]       t_used;

    typedef struct packed {
        t_value value;
        logic   last;
    } t_item;

    typedef struct packed {
        t_value value;
        t_count count;
    } t_entry;

    typedef struct packed {
        t_value value;
        t_occ   occ;
        logic   overflow;
        logic   final_entry;
    } t_result;

    // Requests from the back end to the value match cells.
    typedef struct packed {
        logic   cmp_en;
        t_value cmp_value;
        logic   wr_en;
        t_idx   wr_idx;
        t_value wr_value;
        logic   clear;
    } t_cam_req;

    typedef struct packed {
        logic hit;
        t_idx idx;
    } t_cam_rsp;

endpackage

FILE: src/distinct_value_frequency_counter.sv
`timescale 1ns / 1ps

// Distinct value frequency counter. Signed 32-bit values of a batch are pushed
// one item at a time; the block keeps up to TABLE_DEPTH (64) distinct values in
// order of first appearance with a 16-bit count each that saturates at 65535.
// A value not yet in a full table is dropped and sets overflow_seen. After the
// item flagged batch_end has been counted, one result per stored value comes
// out in first-appearance order, final_entry marking the last, and the table
// is empty again for the next batch. A value that misses goes through the back
// end as a registered match over all value cells, then the append; a value
// that hits goes through the match, then a read and a write of the count
// memory for its count. The end of a batch then reads each stored entry from
// the count memory in turn, pausing while the result queue has no room. A
// four-item queue on the input lets items be pushed while earlier ones are
// still worked on, and a four-item result queue holds results until they are
// popped. No clearing pass is needed after reset or between batches: the valid
// bits of all value cells are cleared together.

module distinct_value_frequency_counter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [31:0]  i_sample_value,
    input  logic                i_batch_end,
    output logic                empty,
    input  logic                pop,
    output logic signed [31:0]  o_distinct_value,
    output logic [15:0]         o_occurrences,
    output logic                o_overflow_seen,
    output logic                o_final_entry
);
    import dvfc_pkg::*;

    t_item     w_head;
    logic      w_head_valid;
    logic      w_head_pop;
    t_cam_req  w_cam_req;
    t_cam_rsp  w_cam_rsp;
    t_result   w_result;

    // Front end: takes items in and queues them for the back end.
    dvfc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_value      (t_value'(i_sample_value)),
        .i_last       (i_batch_end),
        .o_full       (full),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .i_head_pop   (w_head_pop)
    );

    // Value cells: every stored value is compared with the incoming one at once.
    dvfc_cam u_cam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_cam_req),
        .o_rsp   (w_cam_rsp)
    );

    // Back end: counts, appends, and reads the table out at the end of a batch.
    dvfc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_head_pop   (w_head_pop),
        .o_cam_req    (w_cam_req),
        .i_cam_rsp    (w_cam_rsp),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_result     (w_result)
    );

    assign o_distinct_value = w_result.value;
    assign o_occurrences    = w_result.occ;
    assign o_overflow_seen  = w_result.overflow;
    assign o_final_entry    = w_result.final_entry;

endmodule

FILE: src/dvfc_ram.sv
`timescale 1ns / 1ps

module dvfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/dvfc_front.sv
`timescale 1ns / 1ps

module dvfc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dvfc_pkg::t_value    i_value,
    input  logic                i_last,
    output logic                o_full,
    output dvfc_pkg::t_item     o_head,
    output logic                o_head_valid,
    input  logic                i_head_pop
);
    import dvfc_pkg::*;

    t_item               r_q [IQ_DEPTH];
    logic [IQ_PTR_W-1:0] r_wr_ptr;
    logic [IQ_PTR_W-1:0] r_rd_ptr;
    logic [IQ_CNT_W-1:0] r_cnt;
    logic [IQ_PTR_W-1:0] n_wr_ptr;
    logic [IQ_PTR_W-1:0] n_rd_ptr;
    logic [IQ_CNT_W-1:0] n_cnt;
    logic                w_push;
    logic                w_pop;

    assign o_full       = (r_cnt == IQ_CNT_W'(IQ_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rd_ptr];
    assign w_push       = i_push && !o_full;
    assign w_pop        = i_head_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == IQ_PTR_W'(IQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == IQ_PTR_W'(IQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= '{value: i_value, last: i_last};
        end
    end

endmodule

FILE: src/dvfc_cam.sv
`timescale 1ns / 1ps

module dvfc_cam (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dvfc_pkg::t_cam_req  i_req,
    output dvfc_pkg::t_cam_rsp  o_rsp
);
    import dvfc_pkg::*;

    // One cell per table entry: a stored value, a valid bit and a comparator.
    t_value                 r_cell [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [TABLE_DEPTH-1:0] r_hit;
    logic [TABLE_DEPTH-1:0] w_hit;
    t_idx                   w_idx;

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_hit[i] = r_valid[i] && (r_cell[i] == i_req.cmp_value);
        end
    end

    // Stored values are distinct, so at most one bit of r_hit is set and an OR
    // of the indices gives the hit position.
    always_comb begin
        w_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_idx = w_idx | (r_hit[i] ? IDX_W'(i) : '0);
        end
    end

    assign o_rsp.hit = |r_hit;
    assign o_rsp.idx = w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hit   <= '0;
        end else begin
            if (i_req.cmp_en) begin
                r_hit <= w_hit;
            end
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_cell[i_req.wr_idx] <= i_req.wr_value;
        end
    end

`ifndef SYNTHESIS
    a_hit_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_hit))
        else $error("more than one table cell matched");
`endif

endmodule

FILE: src/dvfc_back.sv
`timescale 1ns / 1ps

module dvfc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dvfc_pkg::t_item     i_head,
    input  logic                i_head_valid,
    output logic                o_head_pop,
    output dvfc_pkg::t_cam_req  o_cam_req,
    input  dvfc_pkg::t_cam_rsp  i_cam_rsp,
    output logic                o_empty,
    input  logic                i_pop,
    output dvfc_pkg::t_result   o_result
);
    import dvfc_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MATCH  = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_used      r_used;
    t_used      n_used;
    logic       r_ovf;
    logic       n_ovf;
    t_idx       r_emit_idx;
    t_idx       n_emit_idx;
    logic       r_rd_pend;
    logic       n_rd_pend;

    // Payload registers of the item under way and of the read in flight.
    t_value     r_val;
    logic       r_last;
    t_idx       r_idx;
    logic       r_pend_ovf;
    logic       r_pend_final;

    logic       w_ram_we;
    t_idx       w_ram_waddr;
    t_entry     w_ram_wdata;
    logic       w_ram_re;
    t_idx       w_ram_raddr;
    t_entry     w_ram_rdata;
    logic       w_emit_go;
    logic       w_emit_final;

    // Result queue.
    t_result             r_oq [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_oq_wr;
    logic [OQ_PTR_W-1:0] r_oq_rd;
    logic [OQ_CNT_W-1:0] r_oq_cnt;
    logic                w_oq_pop;

    dvfc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign w_emit_go = (OQ_CNT_W'(r_oq_cnt) + OQ_CNT_W'(r_rd_pend)) < OQ_CNT_W'(OQ_DEPTH);
    assign w_emit_final = (CNT_W'(r_emit_idx) + CNT_W'(1)) == r_used;

    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_ovf      = r_ovf;
        n_emit_idx = r_emit_idx;
        n_rd_pend  = 1'b0;
        o_head_pop = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_idx;
        w_ram_wdata = '{value: r_val, count: COUNT_WIDTH'(1)};
        w_ram_re    = 1'b0;
        w_ram_raddr = r_emit_idx;
        o_cam_req.cmp_en    = 1'b0;
        o_cam_req.cmp_value = i_head.value;
        o_cam_req.wr_en     = 1'b0;
        o_cam_req.wr_idx    = r_used[IDX_W-1:0];
        o_cam_req.wr_value  = r_val;
        o_cam_req.clear     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    o_head_pop       = 1'b1;
                    o_cam_req.cmp_en = 1'b1;
                    n_state          = S_MATCH;
                end
            end
            S_MATCH: begin
                if (i_cam_rsp.hit) begin
                    w_ram_re    = 1'b1;
                    w_ram_raddr = i_cam_rsp.idx;
                    n_state     = S_UPDATE;
                end else begin
                    if (r_used == CNT_W'(TABLE_DEPTH)) begin
                        n_ovf = 1'b1;
                    end else begin
                        w_ram_we        = 1'b1;
                        w_ram_waddr     = r_used[IDX_W-1:0];
                        o_cam_req.wr_en = 1'b1;
                        n_used          = r_used + 1'b1;
                    end
                    n_emit_idx = '0;
                    n_state    = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_UPDATE: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_idx;
                w_ram_wdata.count = (w_ram_rdata.count == '1) ? w_ram_rdata.count
                                                              : w_ram_rdata.count + 1'b1;
                n_emit_idx = '0;
                n_state    = r_last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (w_emit_go) begin
                    w_ram_re  = 1'b1;
                    n_rd_pend = 1'b1;
                    if (w_emit_final) begin
                        n_used          = '0;
                        n_ovf           = 1'b0;
                        o_cam_req.clear = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        n_emit_idx = r_emit_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= '0;
            r_ovf      <= 1'b0;
            r_emit_idx <= '0;
            r_rd_pend  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_ovf      <= n_ovf;
            r_emit_idx <= n_emit_idx;
            r_rd_pend  <= n_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_head_pop) begin
            r_val  <= i_head.value;
            r_last <= i_head.last;
        end
        if (r_state == S_MATCH) begin
            r_idx <= i_cam_rsp.idx;
        end
        if (n_rd_pend) begin
            r_pend_ovf   <= r_ovf;
            r_pend_final <= w_emit_final;
        end
    end

    assign o_empty  = (r_oq_cnt == '0);
    assign o_result = r_oq[r_oq_rd];
    assign w_oq_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (r_rd_pend) begin
                r_oq_wr <= (r_oq_wr == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : r_oq_wr + 1'b1;
            end
            if (w_oq_pop) begin
                r_oq_rd <= (r_oq_rd == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : r_oq_rd + 1'b1;
            end
            if (r_rd_pend && !w_oq_pop) begin
                r_oq_cnt <= r_oq_cnt + 1'b1;
            end else if (w_oq_pop && !r_rd_pend) begin
                r_oq_cnt <= r_oq_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            r_oq[r_oq_wr] <= '{value:       w_ram_rdata.value,
                               occ:         OCC_WIDTH'(w_ram_rdata.count),
                               overflow:    r_pend_ovf,
                               final_entry: r_pend_final};
        end
    end

`ifndef SYNTHESIS
    a_oq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (r_oq_cnt < OQ_CNT_W'(OQ_DEPTH)))
        else $error("table read returned with no room in the result queue");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond the table depth");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_emit_go && w_emit_final)
            |=> (r_used == '0 && !r_ovf && r_rd_pend && r_pend_final))
        else $error("table not cleared after its last entry was read");

    a_pop_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_head_pop |-> (r_state == S_IDLE && i_head_valid))
        else $error("item taken from the queue while another is under way");
`endif

endmodule
